// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit allocator
// Field widths, unit size, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Fixed transaction field widths
  localparam int unsigned BYTES_W  = 15;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned STATUS_W = 2;

  // Heap unit size in bytes (power of two, rounding is a shift)
  localparam int unsigned UNIT_BYTES = 16;
  localparam int unsigned UNIT_SHIFT = $clog2(UNIT_BYTES);

  // Width of a request rounded up to units
  localparam int unsigned NEED_W = BYTES_W + 1 - UNIT_SHIFT;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SPLIT_REM,
    S_SPLIT_CUR,
    S_UNLINK,
    S_DONE
  } ffa_state_e;

endpackage

// ===== hw/rtl/first_fit_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator: first-fit free-list heap allocator
// Size and link memories with a registered read, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o): one transaction is an allocate
//   (kind_i = 0, request_bytes_i) or a free (kind_i = 1, payload_index_i).
//   Output channel (out_valid_o / out_stall_i): exactly one result per input
//   transaction, in order: status_o, granted_index_o, granted_units_o.
// Timing
//   One item is in flight at a time; in_stall_o is high from acceptance
//   until the result has been moved into the output register.
//   Free or zero-size request: straight to S_DONE, then the output register.
//   Allocate: one size and link memory read per free-list chunk visited,
//   one per cycle; a failed walk then goes to S_DONE, a chunk taken whole
//   goes through S_UNLINK, a split through S_SPLIT_REM and S_SPLIT_CUR.
//   The list walk is the bound on throughput.
// Reset
//   The list holds one free chunk at unit 0 spanning the heap. Entry 0 of
//   both memories reads as its reset value until first written; other
//   entries are undefined until written. No clearing pass is needed.
// Backpressure
//   A finished result waits in the output register while out_stall_i is
//   high; the sequencer holds its result until that register frees up.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
  parameter int unsigned HEAP_UNITS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [ffa_pkg::BYTES_W-1:0]    request_bytes_i,
  input  logic [ffa_pkg::IDX_W-1:0]      payload_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ffa_pkg::STATUS_W-1:0]   status_o,
  output logic [ffa_pkg::IDX_W-1:0]      granted_index_o,
  output logic [ffa_pkg::IDX_W-1:0]      granted_units_o
);
  import ffa_pkg::*;

  // Addresses, links (HEAP_UNITS encodes null) and sizes
  localparam int unsigned ADDR_W = $clog2(HEAP_UNITS);
  localparam int unsigned LINK_W = $clog2(HEAP_UNITS + 1);
  localparam int unsigned SIZE_W = ADDR_W;
  localparam int unsigned CMP_W  = ((ADDR_W > NEED_W) ? ADDR_W : NEED_W) + 1;
  localparam int unsigned EXT_W  = ((IDX_W > LINK_W) ? IDX_W : LINK_W) + 1;

  localparam logic [LINK_W-1:0] NIL_LINK   = LINK_W'(HEAP_UNITS);
  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(HEAP_UNITS - 1);

  // --------------------------------------------------------------------------
  // Memories: size and link per header unit, one write and one read a cycle
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] size_mem [HEAP_UNITS];
  logic [LINK_W-1:0] link_mem [HEAP_UNITS];

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [SIZE_W-1:0] rd_size_q;
  logic [LINK_W-1:0] rd_link_q;
  logic              rd_zero_q;

  logic              size_we;
  logic [ADDR_W-1:0] size_waddr;
  logic [SIZE_W-1:0] size_wdata;
  logic              link_we;
  logic [ADDR_W-1:0] link_waddr;
  logic [LINK_W-1:0] link_wdata;

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      rd_size_q <= size_mem[rd_addr];
      rd_link_q <= link_mem[rd_addr];
      rd_zero_q <= (rd_addr == '0);
    end
  end

  // Entry 0 holds its reset value until first written
  logic size0_wr_q, link0_wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size0_wr_q <= 1'b0;
      link0_wr_q <= 1'b0;
    end else begin
      if (size_we && size_waddr == '0) size0_wr_q <= 1'b1;
      if (link_we && link_waddr == '0) link0_wr_q <= 1'b1;
    end
  end

  logic [SIZE_W-1:0] eff_size;
  logic [LINK_W-1:0] eff_link;

  assign eff_size = (rd_zero_q && !size0_wr_q) ? RESET_SIZE : rd_size_q;
  assign eff_link = (rd_zero_q && !link0_wr_q) ? NIL_LINK : rd_link_q;

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  ffa_state_e state_q, state_d;

  logic [LINK_W-1:0]   head_q, head_d;
  logic [LINK_W-1:0]   cur_q, cur_d;        // chunk whose read is in flight
  logic [ADDR_W-1:0]   prev_q, prev_d;
  logic                has_prev_q, has_prev_d;
  logic [LINK_W-1:0]   visits_q, visits_d;
  logic [NEED_W-1:0]   needed_q, needed_d;
  logic [SIZE_W-1:0]   cur_size_q, cur_size_d;
  logic [LINK_W-1:0]   cur_link_q, cur_link_d;
  logic [ADDR_W-1:0]   rem_q, rem_d;
  logic [SIZE_W-1:0]   rem_size_q, rem_size_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_index_q, res_index_d;
  logic [IDX_W-1:0]    res_units_q, res_units_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [IDX_W-1:0]    out_index_q, out_units_q;
  logic                out_load;

  // Datapath helpers
  logic                in_accept;
  logic [BYTES_W:0]    bytes_round;
  logic [EXT_W-1:0]    hdr_ext;
  logic                free_ok;
  logic [CMP_W-1:0]    size_ext, need_ext, surplus, rem_ext;
  logic [LINK_W-1:0]   cur_inc;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign bytes_round = {1'b0, request_bytes_i} + (BYTES_W + 1)'(UNIT_BYTES - 1);
  assign hdr_ext     = EXT_W'(payload_index_i) - EXT_W'(1);
  assign free_ok     = (payload_index_i != '0) && (hdr_ext < EXT_W'(HEAP_UNITS));

  assign size_ext = CMP_W'(eff_size);
  assign need_ext = CMP_W'(needed_q);
  assign surplus  = size_ext - need_ext;
  assign rem_ext  = CMP_W'(cur_q) + CMP_W'(1) + need_ext;
  assign cur_inc  = cur_q + LINK_W'(1);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    has_prev_d   = has_prev_q;
    visits_d     = visits_q;
    needed_d     = needed_q;
    cur_size_d   = cur_size_q;
    cur_link_d   = cur_link_q;
    rem_d        = rem_q;
    rem_size_d   = rem_size_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_units_d  = res_units_q;

    rd_en      = 1'b0;
    rd_addr    = cur_q[ADDR_W-1:0];
    size_we    = 1'b0;
    size_waddr = cur_q[ADDR_W-1:0];
    size_wdata = SIZE_W'(needed_q);
    link_we    = 1'b0;
    link_waddr = prev_q;
    link_wdata = cur_link_q;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_status_d = ST_OK;
          res_index_d  = '0;
          res_units_d  = '0;
          state_d      = S_DONE;
          if (kind_i) begin
            // Free: push on the list head, only a range check on the index, no coalescing
            if (free_ok) begin
              link_we    = 1'b1;
              link_waddr = hdr_ext[ADDR_W-1:0];
              link_wdata = head_q;
              head_d     = LINK_W'(hdr_ext);
            end
          end else if (request_bytes_i == '0) begin
            res_status_d = ST_ZERO;
          end else begin
            needed_d   = bytes_round[BYTES_W:UNIT_SHIFT];
            has_prev_d = 1'b0;
            if (head_q >= NIL_LINK) begin
              res_status_d = ST_NOFIT;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = head_q[ADDR_W-1:0];
              cur_d    = head_q;
              visits_d = LINK_W'(1);
              state_d  = S_EVAL;
            end
          end
        end
      end

      S_EVAL: begin
        if (size_ext >= need_ext) begin
          cur_size_d = eff_size;
          cur_link_d = eff_link;
          rem_d      = rem_ext[ADDR_W-1:0];
          rem_size_d = SIZE_W'(surplus - CMP_W'(1));
          if (surplus >= CMP_W'(2) && rem_ext < CMP_W'(HEAP_UNITS)) begin
            state_d = S_SPLIT_REM;
          end else begin
            state_d = S_UNLINK;
          end
        end else begin
          // Too small: follow the link, reading the next chunk at once
          prev_d     = cur_q[ADDR_W-1:0];
          has_prev_d = 1'b1;
          cur_d      = eff_link;
          if (eff_link >= NIL_LINK || visits_q >= NIL_LINK) begin
            res_status_d = ST_NOFIT;
            state_d      = S_DONE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = eff_link[ADDR_W-1:0];
            visits_d = visits_q + LINK_W'(1);
          end
        end
      end

      S_SPLIT_REM: begin
        size_we    = 1'b1;
        size_waddr = rem_q;
        size_wdata = rem_size_q;
        link_we    = 1'b1;
        link_waddr = rem_q;
        link_wdata = cur_link_q;
        state_d    = S_SPLIT_CUR;
      end

      S_SPLIT_CUR: begin
        size_we    = 1'b1;
        size_waddr = cur_q[ADDR_W-1:0];
        size_wdata = SIZE_W'(needed_q);
        if (has_prev_q) begin
          link_we    = 1'b1;
          link_waddr = prev_q;
          link_wdata = LINK_W'(rem_q);
        end else begin
          head_d = LINK_W'(rem_q);
        end
        res_status_d = ST_OK;
        res_index_d  = IDX_W'(cur_inc);
        res_units_d  = IDX_W'(needed_q);
        state_d      = S_DONE;
      end

      S_UNLINK: begin
        if (has_prev_q) begin
          link_we    = 1'b1;
          link_waddr = prev_q;
          link_wdata = cur_link_q;
        end else begin
          head_d = cur_link_q;
        end
        res_status_d = ST_OK;
        res_index_d  = IDX_W'(cur_inc);
        res_units_d  = IDX_W'(cur_size_q);
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      has_prev_q <= 1'b0;
      visits_q   <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      has_prev_q <= has_prev_d;
      visits_q   <= visits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    needed_q     <= needed_d;
    cur_size_q   <= cur_size_d;
    cur_link_q   <= cur_link_d;
    rem_q        <= rem_d;
    rem_size_q   <= rem_size_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_units_q  <= res_units_d;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_units_q  <= res_units_q;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_index_o = out_index_q;
  assign granted_units_o = out_units_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && (size_we || link_we)))
    else $error("memory read and write in the same cycle");

  a_visits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visits_q <= NIL_LINK)
    else $error("walk visit count beyond heap size");

  a_fail_zero_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_index_o == '0 && granted_units_o == '0)
    else $error("failed result carries grant fields");

  a_split_surplus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SPLIT_REM |-> CMP_W'(cur_size_q) >= CMP_W'(needed_q) + CMP_W'(2))
    else $error("split without a surplus of two units");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && state_q == S_IDLE)
    else $error("result load did not reach the output");

endmodule
